>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check with no reset qualification.
`define TSAG_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");

// Concurrent check, off while reset is high.
`define TSAG_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");

`endif

>>> hw/rtl/tsag_pkg.sv
package tsag_pkg;

   localparam int TILE_W      = 24;
   localparam int ADDR_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 21;

   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_LAYOUT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEM_BYTES_LOG2 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILES_PER_ROW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILES_PER_SLICE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANK_SWIZZLE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIPE_SWIZZLE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANK_SWAP_WIDTH = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SLICE     = 3'd7;

   // 4 banks, 2 pipes, 256-byte group
   localparam int BANK_PIPE_BITS = 3;
   localparam int GROUP_BITS     = 8;

   localparam logic [1:0] SWAP_ORDER [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

   localparam int DIV1_W      = TILE_W;
   localparam int DIV2_W      = TILE_W;
   localparam int DIV3_W      = ADDR_W;
   localparam int RSP_LATENCY = DIV1_W + DIV2_W + DIV3_W + 3;

endpackage

>>> hw/rtl/tsag_divider.sv
module tsag_divider #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [DIVIDEND_W-1:0] in_dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  out_valid,
   output logic [DIVIDEND_W-1:0] out_quotient,
   output logic [DIVIDEND_W-1:0] out_remainder
);

   localparam int EXT_W = DIVIDEND_W + 1;

   logic                  valid_ff [DIVIDEND_W];
   logic [DIVIDEND_W-1:0] rem_ff   [DIVIDEND_W];
   logic [DIVIDEND_W-1:0] dq_ff    [DIVIDEND_W];
   logic [EXT_W-1:0]      divisor_ext;

   assign divisor_ext = EXT_W'(divisor);

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < DIVIDEND_W; k++) begin : g_stage
      logic                  valid_in;
      logic [DIVIDEND_W-1:0] rem_prev;
      logic [DIVIDEND_W-1:0] dq_prev;
      logic [DIVIDEND_W-1:0] rem_in;
      logic [DIVIDEND_W-1:0] dq_in;
      logic [EXT_W-1:0]      part;
      logic                  take;

      if (k == 0) begin : g_first
         assign valid_in = in_valid;
         assign rem_prev = '0;
         assign dq_prev  = in_dividend;
      end else begin : g_next
         assign valid_in = valid_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign dq_prev  = dq_ff[k-1];
      end

      assign part   = {rem_prev, dq_prev[DIVIDEND_W-1]};
      assign take   = part >= divisor_ext;
      assign rem_in = take ? DIVIDEND_W'(part - divisor_ext) : part[DIVIDEND_W-1:0];
      assign dq_in  = {dq_prev[DIVIDEND_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in;
         end
         rem_ff[k] <= rem_in;
         dq_ff[k]  <= dq_in;
      end
   end

   // zero divisor: quotient 0, remainder is the dividend
   assign out_valid     = valid_ff[DIVIDEND_W-1];
   assign out_remainder = rem_ff[DIVIDEND_W-1];
   assign out_quotient  = (divisor == '0) ? '0 : dq_ff[DIVIDEND_W-1];

endmodule

>>> hw/rtl/tiled_surface_address_gen.sv
// Takes one micro-tile transaction per cycle (busy is always low) and strobes its tiled and
// linear byte offsets on rsp_valid, in order. Each request passes through three bit-serial
// divider pipelines of 24, 24 and 32 stages (slice split, row or macro-row split, bank-swap
// step) plus three arithmetic stages. The receiver cannot stall: every result is shown for
// one cycle only. Write the CSRs only while nothing is in flight.
module tiled_surface_address_gen
   import tsag_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [TILE_W-1:0]      req_tile_number,
   output logic                   rsp_valid,
   output logic [ADDR_W-1:0]      rsp_tiled_byte_offset,
   output logic [ADDR_W-1:0]      rsp_linear_byte_offset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   typedef struct packed {
      logic [TILE_W-1:0] slice_tile;
      logic [1:0]        local_slice;
      logic [2:0]        slab_low;
      logic [TILE_W:0]   slab_diff;
   } split_type;

   typedef struct packed {
      logic [TILE_W-1:0] slice_tile;
      logic [1:0]        local_slice;
      logic [2:0]        slab_low;
      logic [ADDR_W-1:0] tile_x;
      logic [2:0]        tile_y_low;
      logic [ADDR_W-1:0] row_tiles;
      logic [ADDR_W-1:0] slab_tiles;
   } place_type;

   logic [6:0]  tile_layout_ff;
   logic [2:0]  ebl_ff;
   logic [10:0] tpr_ff;
   logic [20:0] tps_ff;
   logic [1:0]  bank_swizzle_ff;
   logic        pipe_swizzle_ff;
   logic [14:0] bsw_ff;
   logic [10:0] first_slice_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_layout_ff  <= '0;
         ebl_ff          <= 3'd2;
         tpr_ff          <= 11'd1;
         tps_ff          <= 21'd1;
         bank_swizzle_ff <= '0;
         pipe_swizzle_ff <= 1'b0;
         bsw_ff          <= 15'd1;
         first_slice_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TILE_LAYOUT:     tile_layout_ff  <= csr_write_data[6:0];
            CSR_ELEM_BYTES_LOG2: ebl_ff          <= csr_write_data[2:0];
            CSR_TILES_PER_ROW:   tpr_ff          <= csr_write_data[10:0];
            CSR_TILES_PER_SLICE: tps_ff          <= csr_write_data[20:0];
            CSR_BANK_SWIZZLE:    bank_swizzle_ff <= csr_write_data[1:0];
            CSR_PIPE_SWIZZLE:    pipe_swizzle_ff <= csr_write_data[0];
            CSR_BANK_SWAP_WIDTH: bsw_ff          <= csr_write_data[14:0];
            CSR_FIRST_SLICE:     first_slice_ff  <= csr_write_data[10:0];
         endcase
      end
   end

   // static setup decode
   logic [1:0]        lw, lh;
   logic [2:0]        lwh;
   logic              thick, three_x, swapped, macro_mode;
   logic [2:0]        ebl_sat;
   logic [3:0]        tile_shift, row_shift, slab_shift;
   logic [2:0]        swap_shift;
   logic [13:0]       macro_row_tiles, div2_divisor;
   logic [ADDR_W-1:0] thin_slice_bytes, backup;
   logic [10:0]       fs_hi;
   logic [1:0]        fs_lo;
   logic [TILE_W-1:0] lwh_mask, lw_mask;

   assign lw         = tile_layout_ff[1:0];
   assign lh         = tile_layout_ff[3:2];
   assign thick      = tile_layout_ff[4];
   assign three_x    = tile_layout_ff[5];
   assign swapped    = tile_layout_ff[6];
   assign macro_mode = |tile_layout_ff[3:0];
   assign lwh        = {1'b0, lw} + {1'b0, lh};
   assign ebl_sat    = (ebl_ff > 3'd4) ? 3'd4 : ebl_ff;
   assign tile_shift = {1'b0, ebl_sat} + 4'd6;
   assign row_shift  = {1'b0, ebl_sat} + 4'd3;
   assign slab_shift = tile_shift + (thick ? 4'd2 : 4'd0);
   assign swap_shift = {1'b0, lw} + 3'd3;
   assign lwh_mask   = (TILE_W'(1) << lwh) - TILE_W'(1);
   assign lw_mask    = (TILE_W'(1) << lw) - TILE_W'(1);

   assign macro_row_tiles  = {3'b0, 11'(tpr_ff >> lw)} << lwh;
   assign div2_divisor     = macro_mode ? macro_row_tiles : {3'b0, tpr_ff};
   assign thin_slice_bytes = ADDR_W'(tps_ff) << tile_shift;
   assign fs_hi            = thick ? (first_slice_ff >> 2) : first_slice_ff;
   assign fs_lo            = thick ? first_slice_ff[1:0] : 2'd0;
   assign backup           = ADDR_W'(fs_lo) * thin_slice_bytes;

   assign busy = 1'b0;

   // slice split
   logic              d1_valid;
   logic [TILE_W-1:0] d1_quot, d1_rem;

   tsag_divider #(
      .DIVIDEND_W (DIV1_W),
      .DIVISOR_W  (21)
   ) u_div_slice (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start & ~busy),
      .in_dividend   (req_tile_number),
      .divisor       (tps_ff),
      .out_valid     (d1_valid),
      .out_quotient  (d1_quot),
      .out_remainder (d1_rem)
   );

   logic            a_valid_ff;
   split_type       a_data_ff, a_data_in;
   logic [TILE_W:0] src_slice, slab_idx;

   always_comb begin
      src_slice            = (TILE_W+1)'(first_slice_ff) + (TILE_W+1)'(d1_quot);
      slab_idx             = thick ? (src_slice >> 2) : src_slice;
      a_data_in.slice_tile = d1_rem;
      a_data_in.local_slice = thick ? src_slice[1:0] : 2'd0;
      a_data_in.slab_low   = slab_idx[2:0];
      a_data_in.slab_diff  = slab_idx - (TILE_W+1)'(fs_hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= d1_valid;
      end
      a_data_ff <= a_data_in;
   end

   // row split (1D) or macro-row split
   logic              d2_valid;
   logic [TILE_W-1:0] d2_quot, d2_rem;
   split_type         b_line_ff [DIV2_W];

   tsag_divider #(
      .DIVIDEND_W (DIV2_W),
      .DIVISOR_W  (14)
   ) u_div_row (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (a_valid_ff),
      .in_dividend   (a_data_ff.slice_tile),
      .divisor       (div2_divisor),
      .out_valid     (d2_valid),
      .out_quotient  (d2_quot),
      .out_remainder (d2_rem)
   );

   always_ff @(posedge clock) begin
      b_line_ff[0] <= a_data_ff;
      for (int k = 1; k < DIV2_W; k++) begin
         b_line_ff[k] <= b_line_ff[k-1];
      end
   end

   logic              c_valid_ff;
   place_type         c_data_ff, c_data_in;
   logic [ADDR_W-1:0] c_swap_num_ff, c_swap_num_in;
   logic [TILE_W-1:0] mx, micro;
   logic [ADDR_W-1:0] ty;
   split_type         b_out;

   always_comb begin
      b_out = b_line_ff[DIV2_W-1];
      mx    = d2_rem >> lwh;
      micro = d2_rem & lwh_mask;
      if (macro_mode) begin
         c_data_in.tile_x = (ADDR_W'(mx) << lw) | ADDR_W'(micro & lw_mask);
         ty               = (ADDR_W'(d2_quot) << lh) | ADDR_W'(micro >> lw);
      end else begin
         c_data_in.tile_x = ADDR_W'(d2_rem);
         ty               = ADDR_W'(d2_quot);
      end
      c_data_in.slice_tile  = b_out.slice_tile;
      c_data_in.local_slice = b_out.local_slice;
      c_data_in.slab_low    = b_out.slab_low;
      c_data_in.tile_y_low  = ty[2:0];
      c_data_in.row_tiles   = ty * ADDR_W'(tpr_ff);
      c_data_in.slab_tiles  = ADDR_W'(b_out.slab_diff) * ADDR_W'(tps_ff);
      c_swap_num_in         = ADDR_W'(mx) << swap_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= d2_valid;
      end
      c_data_ff     <= c_data_in;
      c_swap_num_ff <= c_swap_num_in;
   end

   // bank-swap step
   logic              d3_valid;
   logic [ADDR_W-1:0] d3_quot, d3_rem;
   place_type         d_line_ff [DIV3_W];

   tsag_divider #(
      .DIVIDEND_W (DIV3_W),
      .DIVISOR_W  (15)
   ) u_div_swap (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (c_valid_ff),
      .in_dividend   (c_swap_num_ff),
      .divisor       (bsw_ff),
      .out_valid     (d3_valid),
      .out_quotient  (d3_quot),
      .out_remainder (d3_rem)
   );

   always_ff @(posedge clock) begin
      d_line_ff[0] <= c_data_ff;
      for (int k = 1; k < DIV3_W; k++) begin
         d_line_ff[k] <= d_line_ff[k-1];
      end
   end

   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] tiled_ff, tiled_in, linear_ff, linear_in;
   place_type         d_out;
   logic [ADDR_W-1:0] lin_local, tile_local, slice_adv, blk_bytes, base, hi_part;
   logic [1:0]        bank_rot, swap_rot, bank;
   logic              pipe_rot, pipe;

   always_comb begin
      d_out      = d_line_ff[DIV3_W-1];
      lin_local  = ADDR_W'(d_out.local_slice) * thin_slice_bytes;
      tile_local = ADDR_W'(d_out.local_slice) << tile_shift;
      slice_adv  = d_out.slab_tiles << slab_shift;
      blk_bytes  = ADDR_W'(d_out.slice_tile & ~lwh_mask) << slab_shift;
      base       = (blk_bytes >> BANK_PIPE_BITS) + tile_local;
      hi_part    = (base & ~((ADDR_W'(1) << GROUP_BITS) - ADDR_W'(1))) << BANK_PIPE_BITS;
      bank_rot   = three_x ? d_out.slab_low[2:1] : d_out.slab_low[1:0];
      pipe_rot   = three_x & d_out.slab_low[0];
      swap_rot   = swapped ? SWAP_ORDER[d3_quot[1:0]] : 2'd0;
      bank       = {d_out.tile_x[1] ^ d_out.tile_y_low[1], d_out.tile_x[0] ^ d_out.tile_y_low[2]}
                   ^ 2'(bank_swizzle_ff + bank_rot) ^ swap_rot;
      pipe       = d_out.tile_x[0] ^ d_out.tile_y_low[0] ^ pipe_swizzle_ff ^ pipe_rot;
      if (macro_mode) begin
         linear_in = lin_local + (d_out.tile_x << row_shift) + (d_out.row_tiles << tile_shift);
         tiled_in  = hi_part | {21'b0, bank, pipe, base[GROUP_BITS-1:0]};
      end else begin
         linear_in = lin_local + (d_out.tile_x << row_shift)
                     + ((ADDR_W'(d_out.slice_tile) - d_out.tile_x) << tile_shift);
         tiled_in  = tile_local + (ADDR_W'(d_out.slice_tile) << slab_shift);
      end
      tiled_in  = tiled_in + slice_adv;
      linear_in = linear_in + slice_adv - backup;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d3_valid;
      end
      tiled_ff  <= tiled_in;
      linear_ff <= linear_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_tiled_byte_offset  = tiled_ff;
   assign rsp_linear_byte_offset = linear_ff;

endmodule

>>> hw/rtl/tsag_checker.sv
`include "assert_macros.svh"

module tsag_checker
   import tsag_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   `TSAG_ASSERT_RST(a_rsp_from_req, clock, reset, rsp_valid |-> $past(start && !busy && !reset, RSP_LATENCY))
   `TSAG_ASSERT_RST(a_req_to_rsp, clock, reset, start && !busy |-> ##RSP_LATENCY rsp_valid)
   `TSAG_ASSERT_RST(a_quiet_after_reset, clock, reset, $past(reset) |-> !rsp_valid)

endmodule

bind tiled_surface_address_gen tsag_checker u_tsag_checker (.*);

>>> tb/tb_tiled_surface_address_gen.sv
module tb_tiled_surface_address_gen;
   import tsag_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] tiled;
      logic [ADDR_W-1:0] linear;
   } tile_offsets_type;

   class tile_offset_scoreboard;
      int unsigned layout, ebl_reg, per_row, per_slice, bank_swz, pipe_swz, swap_w, first_sl;
      tile_offsets_type pending[$];
      int unsigned mismatches;

      function new();
         layout = 0; ebl_reg = 2; per_row = 1; per_slice = 1;
         bank_swz = 0; pipe_swz = 0; swap_w = 1; first_sl = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, int unsigned val);
         case (idx)
            CSR_TILE_LAYOUT:     layout    = val & 32'h7f;
            CSR_ELEM_BYTES_LOG2: ebl_reg   = val & 32'h7;
            CSR_TILES_PER_ROW:   per_row   = val & 32'h7ff;
            CSR_TILES_PER_SLICE: per_slice = val & 32'h1fffff;
            CSR_BANK_SWIZZLE:    bank_swz  = val & 32'h3;
            CSR_PIPE_SWIZZLE:    pipe_swz  = val & 32'h1;
            CSR_BANK_SWAP_WIDTH: swap_w    = val & 32'h7fff;
            CSR_FIRST_SLICE:     first_sl  = val & 32'h7ff;
            default: ;
         endcase
      endfunction

      function int unsigned quot(int unsigned a, int unsigned b);
         return (b != 0) ? a / b : 32'd0;
      endfunction

      function int unsigned remd(int unsigned a, int unsigned b);
         return (b != 0) ? a % b : a;
      endfunction

      function void note_tile(logic [TILE_W-1:0] tn);
         int unsigned idx, bpe, mw, mh, thick, tile_b, slice_b, thick_b, row_b;
         int unsigned disp, st, src, local_sl, thick_sl, adv, backup, tiled, linear;
         int unsigned per_macro, mpr, pmr, my, in_row, mx, micro, tx, ty, macro_b;
         int unsigned base, hi, lo, bank_rot, pipe_rot, swap_rot, bank, pipe;
         tile_offsets_type e;
         idx = 32'(tn);
         bpe = 32'd1 << ((ebl_reg > 4) ? 4 : ebl_reg);
         mw = 32'd1 << (layout & 3);
         mh = 32'd1 << ((layout >> 2) & 3);
         thick = layout[4] ? 32'd4 : 32'd1;
         tile_b = 32'd64 * bpe;
         slice_b = per_slice * tile_b;
         thick_b = slice_b * thick;
         row_b = per_row * 32'd8 * bpe;
         disp = quot(idx, per_slice);
         st = remd(idx, per_slice);
         src = first_sl + disp;
         local_sl = src % thick;
         thick_sl = src / thick;
         adv = (thick_sl - first_sl / thick) * thick_b;
         backup = (first_sl % thick) * slice_b;
         if (mw == 1 && mh == 1) begin
            ty = quot(st, per_row);
            tx = remd(st, per_row);
            linear = local_sl * slice_b + tx * 32'd8 * bpe + ty * per_row * tile_b;
            tiled = local_sl * tile_b + st * (tile_b * thick);
         end else begin
            per_macro = mw * mh;
            mpr = per_row / mw;
            pmr = per_macro * mpr;
            my = quot(st, pmr);
            in_row = remd(st, pmr);
            mx = in_row / per_macro;
            micro = in_row % per_macro;
            tx = mx * mw + micro % mw;
            ty = my * mh + micro / mw;
            macro_b = per_macro * tile_b * thick;
            linear = local_sl * slice_b + tx * 32'd8 * bpe + ty * 32'd8 * row_b;
            base = (((my * mpr + mx) * macro_b) >> 3) + local_sl * tile_b;
            hi = (base & ~32'hff) << 3;
            lo = base & 32'hff;
            pipe_rot = 0;
            swap_rot = 0;
            if (!layout[5]) begin
               bank_rot = thick_sl;
            end else begin
               bank_rot = thick_sl / 2;
               pipe_rot = thick_sl;
            end
            if (layout[6])
               swap_rot = SWAP_ORDER[quot(mx * 32'd8 * mw, swap_w) & 3];
            bank = ((tx & 1) ^ ((ty >> 2) & 1)) | ((((tx >> 1) & 1) ^ ((ty >> 1) & 1)) << 1);
            bank = bank ^ ((bank_swz + bank_rot) & 3) ^ swap_rot;
            pipe = ((tx ^ ty) & 1) ^ ((pipe_swz + pipe_rot) & 1);
            tiled = (bank << 9) | (pipe << 8) | lo | hi;
         end
         e.tiled = tiled + adv;
         e.linear = linear + adv - backup;
         pending.push_back(e);
      endfunction

      function void check_offsets(logic [ADDR_W-1:0] tiled, logic [ADDR_W-1:0] linear);
         tile_offsets_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response tiled=%h linear=%h", tiled, linear);
            return;
         end
         e = pending.pop_front();
         if (e.tiled !== tiled || e.linear !== linear) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: tiled exp %h got %h, linear exp %h got %h",
                        e.tiled, tiled, e.linear, linear);
         end
      endfunction
   endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   start = 0;
   logic                   busy;
   logic [TILE_W-1:0]      req_tile_number = '0;
   logic                   rsp_valid;
   logic [ADDR_W-1:0]      rsp_tiled_byte_offset;
   logic [ADDR_W-1:0]      rsp_linear_byte_offset;
   logic                   csr_write_enable = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   tile_offset_scoreboard sb = new();
   int unsigned cycles = 0;

   tiled_surface_address_gen u_top (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_tile(req_tile_number);
      if (!reset && rsp_valid)
         sb.check_offsets(rsp_tiled_byte_offset, rsp_linear_byte_offset);
   end

   task automatic send_tile(logic [TILE_W-1:0] tn);
      int gap;
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_tile_number <= tn;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, int unsigned val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= CSR_DATA_W'(val);
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_write_enable <= 0;
   endtask

   task automatic set_surface(int unsigned lay, int unsigned ebl, int unsigned tpr,
                              int unsigned tps, int unsigned bsz, int unsigned psz,
                              int unsigned bsw, int unsigned fsl);
      write_csr(CSR_TILE_LAYOUT, lay);
      write_csr(CSR_ELEM_BYTES_LOG2, ebl);
      write_csr(CSR_TILES_PER_ROW, tpr);
      write_csr(CSR_TILES_PER_SLICE, tps);
      write_csr(CSR_BANK_SWIZZLE, bsz);
      write_csr(CSR_PIPE_SWIZZLE, psz);
      write_csr(CSR_BANK_SWAP_WIDTH, bsw);
      write_csr(CSR_FIRST_SLICE, fsl);
      @(posedge clock);
   endtask

   function automatic int unsigned pick(int unsigned a, int unsigned b, int unsigned lo,
                                        int unsigned hi);
      case ($urandom_range(0, 5))
         0: return a;
         1: return b;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic logic [TILE_W-1:0] rand_tile(int unsigned tps);
      case ($urandom_range(0, 3))
         0: return TILE_W'($urandom_range(0, 255));
         1: return TILE_W'($urandom_range(0, (tps > 0 && tps < 32'h200000) ? tps * 4 : 4096));
         default: return TILE_W'($urandom);
      endcase
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset defaults, then zero divisors, then maximum values, then two further fixed surfaces
      send_tile(0); send_tile(1); send_tile(24'hffffff); send_tile(24'h800000);
      drain();
      set_surface(0, 0, 0, 0, 0, 0, 0, 0);
      send_tile(0); send_tile(5); send_tile(24'hffffff);
      drain();
      set_surface(127, 7, 2047, 32'h1fffff, 3, 1, 32'h7fff, 2047);
      send_tile(0); send_tile(63); send_tile(24'hffffff); send_tile(24'h555555);
      drain();
      set_surface(32'h1f, 4, 1024, 1048576, 2, 1, 16384, 3);
      send_tile(0); send_tile(1); send_tile(2); send_tile(64); send_tile(24'hffffff);
      drain();
      set_surface(32'h65, 1, 1, 64, 1, 0, 1, 1);
      send_tile(0); send_tile(7); send_tile(100); send_tile(24'h0f0f0f);
      drain();

      for (int ph = 0; ph < 16; ph++) begin
         int unsigned lay, tps;
         lay = $urandom_range(0, 127);
         tps = pick(1, 1048576, 1, ($urandom_range(0, 1) != 0) ? 256 : 32'h1fffff);
         set_surface(lay, pick(0, 7, 0, 4), pick(1, 1024, 0, 2047), tps,
                     $urandom_range(0, 3), $urandom_range(0, 1),
                     pick(1, 16384, 0, 32'h7fff), pick(0, 2047, 0, 2047));
         for (int i = 0; i < 90; i++)
            send_tile(rand_tile(tps));
         drain();
      end

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tsag_pkg.sv
hw/rtl/tsag_divider.sv
hw/rtl/tiled_surface_address_gen.sv
hw/rtl/tsag_checker.sv
tb/tb_tiled_surface_address_gen.sv
